@@ design/hnm_pkg.sv @@
// Shared types, constants and state encodings of the height to normal map block.
// Used by every module under design/; depends on nothing else.
package hnm_pkg;

   // Line buffer depth and the geometry limits that follow from it.
   localparam int MAX_WIDTH    = 4096;
   localparam int WIDTH_LIMIT  = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;
   localparam int ADDR_W       = (WIDTH_LIMIT > 1) ? $clog2(WIDTH_LIMIT) : 1;
   localparam int HEIGHT_LIMIT = 4096;

   // Field widths.
   localparam int GEOM_W     = 13;
   localparam int COORD_W    = 12;
   localparam int PIX_W      = 8;
   localparam int SCALE_W    = 20;
   localparam int COMP_W     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   // Arithmetic widths. A scaled difference stays below 2^28, the sum of
   // squares below 2^58, its root below 2^29 and a numerator below 2^30.
   localparam int MAG_W  = PIX_W + SCALE_W;
   localparam int PROD_W = 2 * MAG_W;
   localparam int SQ_W   = 58;
   localparam int LEN_W  = 29;
   localparam int NUM_W  = LEN_W + 1;

   typedef logic [GEOM_W-1:0]     geom_type;
   typedef logic [COORD_W-1:0]    coord_type;
   typedef logic [PIX_W-1:0]      pix_type;
   typedef logic [SCALE_W-1:0]    scale_type;
   typedef logic [COMP_W-1:0]     comp_type;
   typedef logic [ADDR_W-1:0]     addr_type;
   typedef logic [MAG_W-1:0]      mag_type;
   typedef logic [PROD_W-1:0]     prod_type;
   typedef logic [SQ_W-1:0]       sq_type;
   typedef logic [LEN_W-1:0]      len_type;
   typedef logic [NUM_W-1:0]      num_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   // 0.25 in Q16 and its square.
   localparam num_type QUARTER_Q16 = num_type'(16384);
   localparam sq_type  QUARTER_SQ  = sq_type'(1) << 28;
   // Highest even power of two that the sum of squares can reach.
   localparam sq_type  ROOT_FIRST_BIT = sq_type'(1) << (SQ_W - 2);

   // Register reset values.
   localparam geom_type  RESET_WIDTH  = geom_type'(256);
   localparam geom_type  RESET_HEIGHT = geom_type'(256);
   localparam scale_type RESET_SCALE  = scale_type'(65536);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_HEIGHT_SCALE = 2'd2
   } csr_index_type;

   // Normals that one pixel can cause, in output order.
   typedef enum logic [1:0] {
      JOB_ABOVE = 2'd0,
      JOB_LEFT  = 2'd1,
      JOB_SELF  = 2'd2
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_PICK,
      ST_BUSY,
      ST_HOLD
   } hnm_state_type;

   typedef enum logic [3:0] {
      NU_IDLE,
      NU_SCALE,
      NU_SQA,
      NU_SQB,
      NU_SUM,
      NU_ROOT,
      NU_LOAD,
      NU_DIV,
      NU_DONE
   } nu_state_type;

   // Heights of the pixel and of its right and lower neighbors.
   typedef struct packed {
      pix_type center;
      pix_type right;
      pix_type below;
   } nu_req_type;

   typedef struct packed {
      comp_type red;
      comp_type green;
      comp_type blue;
   } nu_res_type;

endpackage

@@ design/hnm_line_buffer.sv @@
// One row of height samples, one write port and two registered read ports.
// Depends on hnm_pkg for the depth and the sample width.
module hnm_line_buffer (
   input  logic             clock,
   input  logic             wr_en,
   input  hnm_pkg::addr_type wr_addr,
   input  hnm_pkg::pix_type  wr_data,
   input  logic             rd_en,
   input  hnm_pkg::addr_type rd_addr_a,
   input  hnm_pkg::addr_type rd_addr_b,
   output hnm_pkg::pix_type  rd_data_a,
   output hnm_pkg::pix_type  rd_data_b
);

   hnm_pkg::pix_type row_store_ff [hnm_pkg::WIDTH_LIMIT];
   hnm_pkg::pix_type rd_a_ff;
   hnm_pkg::pix_type rd_b_ff;

   // Reads return the contents from before a write in the same cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= row_store_ff[rd_addr_a];
         rd_b_ff <= row_store_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ design/hnm_normal_unit.sv @@
// Computes one mapped normal from three heights with a shared compare-subtract
// unit that serves both the square root and the three divisions. Uses hnm_pkg.
module hnm_normal_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  hnm_pkg::nu_req_type req,
   input  hnm_pkg::scale_type  scale,
   output logic                done,
   output hnm_pkg::nu_res_type res
);

   hnm_pkg::nu_state_type state_ff, state_in;

   hnm_pkg::pix_type  mag_a_ff, mag_b_ff;
   logic              neg_a_ff, neg_b_ff;
   hnm_pkg::mag_type  ua_ff, ub_ff;
   hnm_pkg::prod_type prod_ff;
   hnm_pkg::sq_type   acc_ff;
   hnm_pkg::sq_type   rem_ff;
   hnm_pkg::sq_type   root_ff;
   hnm_pkg::sq_type   bit_ff;
   hnm_pkg::sq_type   dv_ff;
   hnm_pkg::comp_type quo_ff;
   logic [2:0]        step_ff;
   logic [1:0]        comp_ff;
   hnm_pkg::comp_type red_ff, green_ff, blue_ff;

   logic [8:0]        diff_a, diff_b, neg_diff_a, neg_diff_b;
   hnm_pkg::pix_type  mag_a, mag_b;
   hnm_pkg::mag_type  sq_op;
   hnm_pkg::prod_type sq_prod;
   hnm_pkg::sq_type   trial;
   hnm_pkg::sq_type   rem_diff;
   logic              take;
   hnm_pkg::len_type  len;
   hnm_pkg::num_type  num;
   hnm_pkg::sq_type   num_scaled;
   hnm_pkg::comp_type quo_next;

   // Height differences toward the right and lower neighbors, as magnitude and sign.
   always_comb begin
      diff_a     = {1'b0, req.right} - {1'b0, req.center};
      diff_b     = {1'b0, req.below} - {1'b0, req.center};
      neg_diff_a = 9'd0 - diff_a;
      neg_diff_b = 9'd0 - diff_b;
      mag_a      = diff_a[8] ? neg_diff_a[7:0] : diff_a[7:0];
      mag_b      = diff_b[8] ? neg_diff_b[7:0] : diff_b[7:0];
   end

   // One squaring multiplier, used for each scaled difference in turn.
   assign sq_op   = (state_ff == hnm_pkg::NU_SQA) ? ua_ff : ub_ff;
   assign sq_prod = hnm_pkg::prod_type'(sq_op) * hnm_pkg::prod_type'(sq_op);

   // The shared compare-subtract unit. During the root it tests the partial
   // root plus the current bit; during a division it tests the shifted divisor.
   assign trial    = (state_ff == hnm_pkg::NU_ROOT) ? (root_ff + bit_ff) : dv_ff;
   assign take     = (rem_ff >= trial);
   assign rem_diff = rem_ff - trial;
   assign quo_next = {quo_ff[hnm_pkg::COMP_W-2:0], take};

   // Numerator of the component in hand: the length plus the signed projection.
   assign len = root_ff[hnm_pkg::LEN_W-1:0];
   always_comb begin
      case (comp_ff)
         2'd0: begin
            num = neg_a_ff ? (hnm_pkg::num_type'(len) + hnm_pkg::num_type'(ua_ff))
                           : (hnm_pkg::num_type'(len) - hnm_pkg::num_type'(ua_ff));
         end
         2'd1: begin
            num = neg_b_ff ? (hnm_pkg::num_type'(len) + hnm_pkg::num_type'(ub_ff))
                           : (hnm_pkg::num_type'(len) - hnm_pkg::num_type'(ub_ff));
         end
         default: begin
            num = hnm_pkg::num_type'(len) + hnm_pkg::QUARTER_Q16;
         end
      endcase
      num_scaled = (hnm_pkg::sq_type'(num) << 8) - hnm_pkg::sq_type'(num);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hnm_pkg::NU_IDLE:  if (start) state_in = hnm_pkg::NU_SCALE;
         hnm_pkg::NU_SCALE: state_in = hnm_pkg::NU_SQA;
         hnm_pkg::NU_SQA:   state_in = hnm_pkg::NU_SQB;
         hnm_pkg::NU_SQB:   state_in = hnm_pkg::NU_SUM;
         hnm_pkg::NU_SUM:   state_in = hnm_pkg::NU_ROOT;
         hnm_pkg::NU_ROOT:  if (bit_ff[0]) state_in = hnm_pkg::NU_LOAD;
         hnm_pkg::NU_LOAD:  state_in = hnm_pkg::NU_DIV;
         hnm_pkg::NU_DIV: begin
            if (step_ff == 3'd7) begin
               state_in = (comp_ff == 2'd2) ? hnm_pkg::NU_DONE : hnm_pkg::NU_LOAD;
            end
         end
         hnm_pkg::NU_DONE:  state_in = hnm_pkg::NU_IDLE;
         default:           state_in = hnm_pkg::NU_IDLE;
      endcase
   end

   always_comb begin
      done = (state_ff == hnm_pkg::NU_DONE);
      res  = '{red: red_ff, green: green_ff, blue: blue_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hnm_pkg::NU_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         hnm_pkg::NU_IDLE: begin
            mag_a_ff <= mag_a;
            mag_b_ff <= mag_b;
            neg_a_ff <= diff_a[8];
            neg_b_ff <= diff_b[8];
         end
         hnm_pkg::NU_SCALE: begin
            ua_ff <= hnm_pkg::mag_type'(mag_a_ff) * hnm_pkg::mag_type'(scale);
            ub_ff <= hnm_pkg::mag_type'(mag_b_ff) * hnm_pkg::mag_type'(scale);
         end
         hnm_pkg::NU_SQA: begin
            prod_ff <= sq_prod;
         end
         hnm_pkg::NU_SQB: begin
            acc_ff  <= hnm_pkg::sq_type'(prod_ff) + hnm_pkg::QUARTER_SQ;
            prod_ff <= sq_prod;
         end
         hnm_pkg::NU_SUM: begin
            rem_ff  <= acc_ff + hnm_pkg::sq_type'(prod_ff);
            root_ff <= '0;
            bit_ff  <= hnm_pkg::ROOT_FIRST_BIT;
            comp_ff <= 2'd0;
         end
         hnm_pkg::NU_ROOT: begin
            if (take) begin
               rem_ff  <= rem_diff;
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         hnm_pkg::NU_LOAD: begin
            // Divide 255*num by 2*len; the quotient never exceeds 255.
            rem_ff  <= num_scaled;
            dv_ff   <= hnm_pkg::sq_type'(len) << 8;
            quo_ff  <= '0;
            step_ff <= 3'd0;
         end
         hnm_pkg::NU_DIV: begin
            if (take) begin
               rem_ff <= rem_diff;
            end
            quo_ff  <= quo_next;
            dv_ff   <= dv_ff >> 1;
            step_ff <= step_ff + 3'd1;
            if (step_ff == 3'd7) begin
               case (comp_ff)
                  2'd0:    red_ff   <= quo_next;
                  2'd1:    green_ff <= quo_next;
                  default: blue_ff  <= quo_next;
               endcase
               comp_ff <= comp_ff + 2'd1;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

@@ design/height_to_normal_map.sv @@
// Height map to normal map converter. Height samples arrive as beats in raster
// order; one row is kept in a line buffer, and each pixel's normal is formed
// from forward differences toward its right and lower neighbors (clamped at
// the image edges), normalized with an integer square root and mapped to three
// 8-bit color components. The normal of the pixel above comes out when a pixel
// arrives; on the last row the left neighbor's normal and, at the last column,
// the pixel's own normal follow, and rsp_last marks the final result beat of
// each input beat. An input beat is taken only while the block is idle, and
// its normals are worked out one after another by the single compare-subtract
// unit, which runs 29 square root steps and three 8-step divisions in turn,
// with setup and hand-over states around them. A finished normal waits in an
// output register, so the next normal's work overlaps a stalled result
// channel. The line buffer needs no clearing pass: each entry is written by
// the first row before any row reads it. Geometry and scale registers are
// written through the csr_ port; the user must write them only while idle,
// as the block itself does not enforce it.
// Depends on hnm_pkg, hnm_line_buffer and hnm_normal_unit.
module height_to_normal_map (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [hnm_pkg::PIX_W-1:0]           req_height,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [hnm_pkg::COMP_W-1:0]          rsp_normal_red,
   output logic [hnm_pkg::COMP_W-1:0]          rsp_normal_green,
   output logic [hnm_pkg::COMP_W-1:0]          rsp_normal_blue,
   output logic [hnm_pkg::COORD_W-1:0]         rsp_column,
   output logic [hnm_pkg::COORD_W-1:0]         rsp_row,
   output logic                                rsp_last,

   input  logic                                csr_write_en,
   input  logic [hnm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [hnm_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   hnm_pkg::hnm_state_type state_ff, state_in;

   // Configuration registers.
   hnm_pkg::geom_type  image_width_ff;
   hnm_pkg::geom_type  image_height_ff;
   hnm_pkg::scale_type height_scale_ff;

   // Stream position and the previous sample.
   hnm_pkg::coord_type column_count_ff;
   hnm_pkg::coord_type row_count_ff;
   hnm_pkg::pix_type   left_height_ff;

   // The pixel in work.
   hnm_pkg::coord_type x_ff, y_ff;
   hnm_pkg::pix_type   px_ff;
   hnm_pkg::pix_type   left_prev_ff;
   logic               right_edge_ff;
   logic [2:0]         jobs_ff;
   hnm_pkg::job_type   cur_ff;

   // Output register.
   logic               rsp_valid_ff;
   hnm_pkg::comp_type  red_ff, green_ff, blue_ff;
   hnm_pkg::coord_type column_ff, row_ff;
   logic               last_ff;

   logic               accept;
   logic               mem_en;
   logic               nu_start;
   logic               load;
   hnm_pkg::geom_type  width_eff, height_eff;
   hnm_pkg::geom_type  cc_ext, rc_ext, row_step, x_new, y_new, x_next, y_next;
   logic               at_right, last_row;
   logic [2:0]         jobs_new;
   logic               pick_found;
   hnm_pkg::job_type   pick_job;
   hnm_pkg::coord_type x_plus;
   hnm_pkg::pix_type   above_c, above_r;
   hnm_pkg::nu_req_type nu_req;
   hnm_pkg::nu_res_type nu_res;
   logic               nu_done;
   logic [2:0]         jobs_rest;
   hnm_pkg::coord_type out_column, out_row;

   // Geometry as used: zero counts as one, and values above the limits clamp.
   always_comb begin
      if (image_width_ff == '0) begin
         width_eff = hnm_pkg::geom_type'(1);
      end else if (image_width_ff > hnm_pkg::geom_type'(hnm_pkg::WIDTH_LIMIT)) begin
         width_eff = hnm_pkg::geom_type'(hnm_pkg::WIDTH_LIMIT);
      end else begin
         width_eff = image_width_ff;
      end
      if (image_height_ff == '0) begin
         height_eff = hnm_pkg::geom_type'(1);
      end else if (image_height_ff > hnm_pkg::geom_type'(hnm_pkg::HEIGHT_LIMIT)) begin
         height_eff = hnm_pkg::geom_type'(hnm_pkg::HEIGHT_LIMIT);
      end else begin
         height_eff = image_height_ff;
      end
   end

   // Position of the arriving pixel. The counters wrap here as well, which
   // only matters when the geometry was changed in the middle of a frame.
   always_comb begin
      cc_ext = {1'b0, column_count_ff};
      rc_ext = {1'b0, row_count_ff};
      if (cc_ext >= width_eff) begin
         x_new    = '0;
         row_step = rc_ext + hnm_pkg::geom_type'(1);
      end else begin
         x_new    = cc_ext;
         row_step = rc_ext;
      end
      y_new    = (row_step >= height_eff) ? '0 : row_step;
      at_right = (x_new + hnm_pkg::geom_type'(1)) >= width_eff;
      last_row = (y_new == height_eff - hnm_pkg::geom_type'(1));
      if (at_right) begin
         x_next = '0;
         y_next = ((y_new + hnm_pkg::geom_type'(1)) >= height_eff) ? '0
                : (y_new + hnm_pkg::geom_type'(1));
      end else begin
         x_next = x_new + hnm_pkg::geom_type'(1);
         y_next = y_new;
      end
      jobs_new = '0;
      jobs_new[hnm_pkg::JOB_ABOVE] = (y_new != '0);
      jobs_new[hnm_pkg::JOB_LEFT]  = last_row && (x_new != '0);
      jobs_new[hnm_pkg::JOB_SELF]  = last_row && at_right;
   end

   // The lowest pending job goes next, which keeps the output order.
   always_comb begin
      pick_found = 1'b1;
      if (jobs_ff[hnm_pkg::JOB_ABOVE]) begin
         pick_job = hnm_pkg::JOB_ABOVE;
      end else if (jobs_ff[hnm_pkg::JOB_LEFT]) begin
         pick_job = hnm_pkg::JOB_LEFT;
      end else if (jobs_ff[hnm_pkg::JOB_SELF]) begin
         pick_job = hnm_pkg::JOB_SELF;
      end else begin
         pick_job   = hnm_pkg::JOB_ABOVE;
         pick_found = 1'b0;
      end
   end

   assign x_plus = x_ff + hnm_pkg::coord_type'(1);

   hnm_line_buffer u_line_buffer (
      .clock     (clock),
      .wr_en     (mem_en),
      .wr_addr   (x_ff[hnm_pkg::ADDR_W-1:0]),
      .wr_data   (px_ff),
      .rd_en     (mem_en),
      .rd_addr_a (x_ff[hnm_pkg::ADDR_W-1:0]),
      .rd_addr_b (x_plus[hnm_pkg::ADDR_W-1:0]),
      .rd_data_a (above_c),
      .rd_data_b (above_r)
   );

   // Operands of each job. For the normal above, the lower neighbor is the
   // arriving sample; at the right edge the right neighbor clamps to the pixel.
   always_comb begin
      case (pick_job)
         hnm_pkg::JOB_ABOVE: begin
            nu_req = '{center: above_c,
                       right:  right_edge_ff ? above_c : above_r,
                       below:  px_ff};
         end
         hnm_pkg::JOB_LEFT: begin
            nu_req = '{center: left_prev_ff, right: px_ff, below: left_prev_ff};
         end
         default: begin
            nu_req = '{center: px_ff, right: px_ff, below: px_ff};
         end
      endcase
   end

   hnm_normal_unit u_normal_unit (
      .clock (clock),
      .reset (reset),
      .start (nu_start),
      .req   (nu_req),
      .scale (height_scale_ff),
      .done  (nu_done),
      .res   (nu_res)
   );

   // Coordinates and the last flag of the job whose result is loaded.
   always_comb begin
      jobs_rest         = jobs_ff;
      jobs_rest[cur_ff] = 1'b0;
      case (cur_ff)
         hnm_pkg::JOB_ABOVE: begin
            out_column = x_ff;
            out_row    = y_ff - hnm_pkg::coord_type'(1);
         end
         hnm_pkg::JOB_LEFT: begin
            out_column = x_ff - hnm_pkg::coord_type'(1);
            out_row    = y_ff;
         end
         default: begin
            out_column = x_ff;
            out_row    = y_ff;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hnm_pkg::ST_IDLE: if (accept) state_in = hnm_pkg::ST_READ;
         hnm_pkg::ST_READ: state_in = hnm_pkg::ST_PICK;
         hnm_pkg::ST_PICK: state_in = pick_found ? hnm_pkg::ST_BUSY : hnm_pkg::ST_IDLE;
         hnm_pkg::ST_BUSY: if (nu_done) state_in = hnm_pkg::ST_HOLD;
         hnm_pkg::ST_HOLD: if (load) state_in = hnm_pkg::ST_PICK;
         default:          state_in = hnm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == hnm_pkg::ST_IDLE);
      accept    = req_valid && req_ready;
      mem_en    = (state_ff == hnm_pkg::ST_READ);
      nu_start  = (state_ff == hnm_pkg::ST_PICK) && pick_found;
      load      = (state_ff == hnm_pkg::ST_HOLD) && (!rsp_valid_ff || rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= hnm_pkg::ST_IDLE;
         image_width_ff  <= hnm_pkg::RESET_WIDTH;
         image_height_ff <= hnm_pkg::RESET_HEIGHT;
         height_scale_ff <= hnm_pkg::RESET_SCALE;
         column_count_ff <= '0;
         row_count_ff    <= '0;
         left_height_ff  <= '0;
         jobs_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_en) begin
            case (csr_index)
               hnm_pkg::CSR_IMAGE_WIDTH:  image_width_ff  <= csr_write_data[hnm_pkg::GEOM_W-1:0];
               hnm_pkg::CSR_IMAGE_HEIGHT: image_height_ff <= csr_write_data[hnm_pkg::GEOM_W-1:0];
               hnm_pkg::CSR_HEIGHT_SCALE: height_scale_ff <= csr_write_data;
               default: begin
               end
            endcase
         end
         // The stream position moves on as soon as the beat is taken.
         if (accept) begin
            column_count_ff <= x_next[hnm_pkg::COORD_W-1:0];
            row_count_ff    <= y_next[hnm_pkg::COORD_W-1:0];
            left_height_ff  <= req_height;
            jobs_ff         <= jobs_new;
         end else if (load) begin
            jobs_ff <= jobs_rest;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff          <= x_new[hnm_pkg::COORD_W-1:0];
         y_ff          <= y_new[hnm_pkg::COORD_W-1:0];
         px_ff         <= req_height;
         left_prev_ff  <= left_height_ff;
         right_edge_ff <= at_right;
      end
      if (nu_start) begin
         cur_ff <= pick_job;
      end
      if (load) begin
         red_ff    <= nu_res.red;
         green_ff  <= nu_res.green;
         blue_ff   <= nu_res.blue;
         column_ff <= out_column;
         row_ff    <= out_row;
         last_ff   <= (jobs_rest == '0);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_normal_red   = red_ff;
   assign rsp_normal_green = green_ff;
   assign rsp_normal_blue  = blue_ff;
   assign rsp_column       = column_ff;
   assign rsp_row          = row_ff;
   assign rsp_last         = last_ff;

`ifndef SYNTH
   // The normal unit only finishes while the controller waits for it.
   assert property (@(posedge clock) disable iff (reset)
      nu_done |-> (state_ff == hnm_pkg::ST_BUSY))
      else $error("normal unit finished outside of the busy state");

   // The result being handed over belongs to a job that is still pending.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == hnm_pkg::ST_HOLD) |-> jobs_ff[cur_ff])
      else $error("held result has no pending job");

   // The z component is never negative, so blue is at least the midpoint.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (blue_ff >= hnm_pkg::comp_type'(127)))
      else $error("blue component below the midpoint");

   // A new pixel is taken only after every normal of the previous one is loaded.
   assert property (@(posedge clock) disable iff (reset)
      accept |-> (jobs_ff == '0))
      else $error("pixel accepted while normals were still pending");
`endif

endmodule
